// File: rtl/toycpu_pkg.sv
// Shared types, codes and constants of the toy CPU execute step.
// No dependencies; every other file refers to this package by scoped names.
package toycpu_pkg;

    localparam int DATA_W            = 32;
    localparam int ADDR_BITS_DEFAULT = 16;
    localparam int OFFSET_W          = 20;
    localparam int MEM_ADDR_OUT_W    = 16;
    localparam int NUM_REGS          = 8;
    localparam int REG_IDX_W         = 3;
    localparam int CNT_W             = $clog2(DATA_W);

    // opcode field, bits 31:28
    localparam logic [3:0] OP_ALU    = 4'd0;
    localparam logic [3:0] OP_LOADI  = 4'd1;
    localparam logic [3:0] OP_STOREI = 4'd2;
    localparam logic [3:0] OP_LOAD   = 4'd3;
    localparam logic [3:0] OP_STORE  = 4'd4;

    // alu op field, bits 15:12
    localparam logic [3:0] ALU_ADD = 4'd0;
    localparam logic [3:0] ALU_SUB = 4'd1;
    localparam logic [3:0] ALU_MUL = 4'd2;
    localparam logic [3:0] ALU_DIV = 4'd3;
    localparam logic [3:0] ALU_MOD = 4'd4;

    localparam logic [DATA_W-1:0] PC_RESET = 32'd1024;
    localparam logic [DATA_W-1:0] PC_STEP  = 32'd4;

    localparam logic [DATA_W-1:0] RF_RESET [NUM_REGS] =
        '{32'd4, 32'd5, 32'd10, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_OP   = 2'd1,
        ST_BAD_REG  = 2'd2,
        ST_DIV_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_MOD = 2'd2
    } md_op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_ISSUE,
        S_LOAD,
        S_MULDIV,
        S_COMMIT
    } state_t;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic decode;
        logic issue;
        logic load_cap;
        logic md_start;
        logic md_cap;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dec_err;
        logic is_load;
        logic is_store;
        logic is_md;
        logic div_zero;
        logic clr_last;
        logic md_done;
        logic out_busy;
    } dp_status_t;

endpackage

// File: rtl/toycpu_if.sv
// Valid/ready channel interfaces: instruction beats in, result beats out.
// Depends on toycpu_pkg for widths.
interface toycpu_in_if;
    logic                           valid;
    logic                           ready;
    logic [toycpu_pkg::DATA_W-1:0]  instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface toycpu_out_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic                                   reg_written;
    logic [toycpu_pkg::REG_IDX_W-1:0]       dest_index;
    logic [toycpu_pkg::DATA_W-1:0]          write_value;
    logic [toycpu_pkg::MEM_ADDR_OUT_W-1:0]  mem_address;
    logic [toycpu_pkg::DATA_W-1:0]          mem_data;
    logic                                   carry_flag;
    logic [toycpu_pkg::DATA_W-1:0]          pc_value;

    modport source (output valid, output status, output reg_written, output dest_index,
                    output write_value, output mem_address, output mem_data,
                    output carry_flag, output pc_value, input ready);
    modport sink   (input valid, input status, input reg_written, input dest_index,
                    input write_value, input mem_address, input mem_data,
                    input carry_flag, input pc_value, output ready);
endinterface

// File: rtl/toycpu_muldiv.sv
// Iterative multiply / divide unit: one bit per cycle over the 32-bit operands.
// Shift-and-add multiply with partial-sum carry, restoring unsigned divide.
// Depends on toycpu_pkg.
module toycpu_muldiv (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  toycpu_pkg::md_op_t             op,
    input  logic [toycpu_pkg::DATA_W-1:0]  a,
    input  logic [toycpu_pkg::DATA_W-1:0]  b,
    output logic                           done,
    output logic [toycpu_pkg::DATA_W-1:0]  result,
    output logic                           carry
);
    localparam int W = toycpu_pkg::DATA_W;
    localparam logic [toycpu_pkg::CNT_W-1:0] CNT_LAST = toycpu_pkg::CNT_W'(W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [toycpu_pkg::CNT_W-1:0] cnt_reg;
    toycpu_pkg::md_op_t           op_reg;
    logic [W-1:0]                 acc_reg;
    logic [W-1:0]                 ash_reg;
    logic [W-1:0]                 bsh_reg;
    logic                         cy_reg;
    logic [W-1:0]                 rem_reg;
    logic [W-1:0]                 quo_reg;
    logic [W-1:0]                 dvs_reg;

    logic [W:0]   sum_next;
    logic [W+1:0] diff_next;

    assign sum_next  = {1'b0, acc_reg} + {1'b0, ash_reg};
    assign diff_next = {1'b0, rem_reg, quo_reg[W-1]} - {2'b00, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg  <= op;
            acc_reg <= '0;
            ash_reg <= a;
            bsh_reg <= b;
            cy_reg  <= 1'b0;
            rem_reg <= '0;
            quo_reg <= a;
            dvs_reg <= b;
        end
        else if (busy_reg)
        begin
            // multiply: add shifted multiplicand where the multiplier bit is set
            if (bsh_reg[0])
            begin
                acc_reg <= sum_next[W-1:0];
                cy_reg  <= cy_reg | sum_next[W];
            end
            ash_reg <= {ash_reg[W-2:0], 1'b0};
            bsh_reg <= {1'b0, bsh_reg[W-1:1]};
            // divide: keep the trial difference unless it went negative
            if (!diff_next[W+1])
            begin
                rem_reg <= diff_next[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        case (op_reg)
            toycpu_pkg::MD_MUL: result = acc_reg;
            toycpu_pkg::MD_DIV: result = quo_reg;
            default:            result = rem_reg;
        endcase
    end

    assign done  = done_reg;
    assign carry = cy_reg;

endmodule

// File: rtl/toycpu_dpath.sv
// Datapath: instruction register, register file, data memory with clearing
// counter, ALU, result staging and output register.
// Depends on toycpu_pkg and toycpu_muldiv; driven by toycpu_ctrl commands.
module toycpu_dpath #(
    parameter int ADDR_BITS = toycpu_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  toycpu_pkg::ctrl_cmd_t                  cmd,
    output toycpu_pkg::dp_status_t                 sts,
    input  logic [toycpu_pkg::DATA_W-1:0]          instruction,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [1:0]                             out_status,
    output logic                                   out_reg_written,
    output logic [toycpu_pkg::REG_IDX_W-1:0]       out_dest_index,
    output logic [toycpu_pkg::DATA_W-1:0]          out_write_value,
    output logic [toycpu_pkg::MEM_ADDR_OUT_W-1:0]  out_mem_address,
    output logic [toycpu_pkg::DATA_W-1:0]          out_mem_data,
    output logic                                   out_carry_flag,
    output logic [toycpu_pkg::DATA_W-1:0]          out_pc_value
);
    localparam int W         = toycpu_pkg::DATA_W;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;
    localparam int EXT_W     = ADDR_BITS + toycpu_pkg::MEM_ADDR_OUT_W;

    // architectural state
    logic [W-1:0]           rf_reg [toycpu_pkg::NUM_REGS];
    logic [7:0]             mem [MEM_DEPTH];
    logic [ADDR_BITS-1:0]   mar_reg;
    logic [W-1:0]           mdr_reg;
    logic                   flag_reg;
    logic [W-1:0]           pc_reg;
    logic [ADDR_BITS-1:0]   clr_reg;

    // per-instruction working registers
    logic [W-1:0]           ir_reg;
    logic [W-1:0]           opa_reg;
    logic [W-1:0]           opb_reg;
    logic [7:0]             rdata_reg;
    toycpu_pkg::status_t    status_reg;
    logic                   wr_reg;
    logic [W-1:0]           wval_reg;
    logic                   fl_upd_reg;
    logic                   fl_val_reg;

    logic                   out_valid_reg;

    // decode fields
    logic [3:0] op, rd, s1, s2, alu, base;
    logic [toycpu_pkg::OFFSET_W-1:0] offset;
    logic is_alu, is_load, is_store, uses_base, is_md;
    toycpu_pkg::status_t dec_status;
    toycpu_pkg::md_op_t  md_op;

    logic [W-1:0]           addr_full;
    logic [ADDR_BITS-1:0]   mem_addr;
    logic                   mem_we;
    logic                   mem_re;
    logic [7:0]             mem_wdata;
    logic [W:0]             add_sum;
    logic [W-1:0]           sub_abs;
    logic                   div_zero;
    logic                   flag_next;
    logic [W-1:0]           pc_next;
    logic [EXT_W-1:0]       mar_ext;

    logic                   md_done;
    logic [W-1:0]           md_result;
    logic                   md_carry;

    assign op     = ir_reg[31:28];
    assign rd     = ir_reg[27:24];
    assign s1     = ir_reg[23:20];
    assign s2     = ir_reg[19:16];
    assign alu    = ir_reg[15:12];
    assign offset = ir_reg[23:4];
    assign base   = ir_reg[3:0];

    assign is_alu    = (op == toycpu_pkg::OP_ALU);
    assign is_load   = op inside {toycpu_pkg::OP_LOADI, toycpu_pkg::OP_LOAD};
    assign is_store  = op inside {toycpu_pkg::OP_STOREI, toycpu_pkg::OP_STORE};
    assign uses_base = op inside {toycpu_pkg::OP_LOAD, toycpu_pkg::OP_STORE};
    assign is_md     = is_alu &&
                       (alu inside {toycpu_pkg::ALU_MUL, toycpu_pkg::ALU_DIV,
                                    toycpu_pkg::ALU_MOD});

    // register index checks come before the alu op check
    always_comb
    begin
        if (op > toycpu_pkg::OP_STORE)
            dec_status = toycpu_pkg::ST_BAD_OP;
        else if (rd[3])
            dec_status = toycpu_pkg::ST_BAD_REG;
        else if (is_alu)
        begin
            if (s1[3] || s2[3])
                dec_status = toycpu_pkg::ST_BAD_REG;
            else if (alu > toycpu_pkg::ALU_MOD)
                dec_status = toycpu_pkg::ST_BAD_OP;
            else
                dec_status = toycpu_pkg::ST_OK;
        end
        else if (uses_base && base[3])
            dec_status = toycpu_pkg::ST_BAD_REG;
        else
            dec_status = toycpu_pkg::ST_OK;
    end

    always_comb
    begin
        case (alu)
            toycpu_pkg::ALU_MUL: md_op = toycpu_pkg::MD_MUL;
            toycpu_pkg::ALU_DIV: md_op = toycpu_pkg::MD_DIV;
            default:             md_op = toycpu_pkg::MD_MOD;
        endcase
    end

    assign div_zero = is_alu && (alu inside {toycpu_pkg::ALU_DIV, toycpu_pkg::ALU_MOD}) &&
                      (opb_reg == '0);

    assign add_sum = {1'b0, opa_reg} + {1'b0, opb_reg};
    assign sub_abs = (opa_reg < opb_reg) ? (opb_reg - opa_reg) : (opa_reg - opb_reg);

    // address wraps to the memory size
    assign addr_full = uses_base ? (opa_reg + W'(offset)) : W'(offset);
    assign mem_addr  = cmd.clr_en ? clr_reg : addr_full[ADDR_BITS-1:0];
    assign mem_we    = cmd.clr_en | (cmd.issue & is_store);
    assign mem_re    = cmd.issue & is_load;
    assign mem_wdata = cmd.clr_en ? 8'h00 : opb_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_en)
            clr_reg <= clr_reg + 1'b1;
    end

    assign flag_next = fl_upd_reg ? fl_val_reg : flag_reg;
    assign pc_next   = (status_reg == toycpu_pkg::ST_OK) ? (pc_reg + toycpu_pkg::PC_STEP)
                                                         : pc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < toycpu_pkg::NUM_REGS; i++)
                rf_reg[i] <= toycpu_pkg::RF_RESET[i];
            mar_reg  <= '0;
            mdr_reg  <= '0;
            flag_reg <= 1'b0;
            pc_reg   <= toycpu_pkg::PC_RESET;
        end
        else
        begin
            if (cmd.issue && (is_load || is_store))
                mar_reg <= addr_full[ADDR_BITS-1:0];
            if (cmd.issue && is_store)
                mdr_reg <= opb_reg;
            if (cmd.load_cap)
                mdr_reg <= W'(rdata_reg);
            if (cmd.commit)
            begin
                if (wr_reg)
                    rf_reg[rd[toycpu_pkg::REG_IDX_W-1:0]] <= wval_reg;
                flag_reg <= flag_next;
                pc_reg   <= pc_next;
            end
        end
    end

    toycpu_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .op     (md_op),
        .a      (opa_reg),
        .b      (opb_reg),
        .done   (md_done),
        .result (md_result),
        .carry  (md_carry)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            ir_reg <= instruction;
        if (cmd.decode)
        begin
            // port A: first source or base, port B: second source or store data
            opa_reg    <= rf_reg[is_alu ? s1[toycpu_pkg::REG_IDX_W-1:0]
                                        : base[toycpu_pkg::REG_IDX_W-1:0]];
            opb_reg    <= rf_reg[is_alu ? s2[toycpu_pkg::REG_IDX_W-1:0]
                                        : rd[toycpu_pkg::REG_IDX_W-1:0]];
            status_reg <= dec_status;
            wr_reg     <= 1'b0;
            fl_upd_reg <= 1'b0;
            fl_val_reg <= 1'b0;
        end
        if (cmd.issue && is_alu)
        begin
            if (div_zero)
                status_reg <= toycpu_pkg::ST_DIV_ZERO;
            else if (alu == toycpu_pkg::ALU_ADD)
            begin
                wval_reg   <= add_sum[W-1:0];
                wr_reg     <= 1'b1;
                fl_upd_reg <= 1'b1;
                fl_val_reg <= add_sum[W];
            end
            else if (alu == toycpu_pkg::ALU_SUB)
            begin
                wval_reg   <= sub_abs;
                wr_reg     <= 1'b1;
                fl_upd_reg <= 1'b1;
                fl_val_reg <= 1'b0;
            end
        end
        if (cmd.load_cap)
        begin
            wval_reg <= W'(rdata_reg);
            wr_reg   <= 1'b1;
        end
        if (cmd.md_cap)
        begin
            // divide keeps the flag, modulo clears it
            wval_reg   <= md_result;
            wr_reg     <= 1'b1;
            fl_upd_reg <= (md_op != toycpu_pkg::MD_DIV);
            fl_val_reg <= (md_op == toycpu_pkg::MD_MUL) ? md_carry : 1'b0;
        end
    end

    assign mar_ext = EXT_W'(mar_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.commit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_status      <= status_reg;
            out_reg_written <= wr_reg;
            out_dest_index  <= wr_reg ? rd[toycpu_pkg::REG_IDX_W-1:0] : '0;
            out_write_value <= wr_reg ? wval_reg : '0;
            out_mem_address <= mar_ext[toycpu_pkg::MEM_ADDR_OUT_W-1:0];
            out_mem_data    <= mdr_reg;
            out_carry_flag  <= flag_next;
            out_pc_value    <= pc_next;
        end
    end

    assign out_valid = out_valid_reg;

    assign sts.dec_err  = (dec_status != toycpu_pkg::ST_OK);
    assign sts.is_load  = is_load;
    assign sts.is_store = is_store;
    assign sts.is_md    = is_md;
    assign sts.div_zero = div_zero;
    assign sts.clr_last = &clr_reg;
    assign sts.md_done  = md_done;
    assign sts.out_busy = out_valid_reg & ~out_ready;

    assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |=> out_valid_reg)
        else $error("result beat not presented after commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && is_store) |-> (status_reg == toycpu_pkg::ST_OK))
        else $error("store issued for a faulted instruction");

endmodule

// File: rtl/toycpu_ctrl.sv
// Controller state machine: memory clearing pass, accept, decode, issue,
// load / multiply-divide wait and commit. Depends on toycpu_pkg.
module toycpu_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  toycpu_pkg::dp_status_t  sts,
    output toycpu_pkg::ctrl_cmd_t   cmd
);
    toycpu_pkg::state_t state_reg;
    toycpu_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= toycpu_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            toycpu_pkg::S_CLEAR:
                if (sts.clr_last)
                    state_next = toycpu_pkg::S_IDLE;
            toycpu_pkg::S_IDLE:
                if (in_valid)
                    state_next = toycpu_pkg::S_DECODE;
            toycpu_pkg::S_DECODE:
                state_next = sts.dec_err ? toycpu_pkg::S_COMMIT : toycpu_pkg::S_ISSUE;
            toycpu_pkg::S_ISSUE:
                if (sts.is_load)
                    state_next = toycpu_pkg::S_LOAD;
                else if (sts.is_md && !sts.div_zero)
                    state_next = toycpu_pkg::S_MULDIV;
                else
                    state_next = toycpu_pkg::S_COMMIT;
            toycpu_pkg::S_LOAD:
                state_next = toycpu_pkg::S_COMMIT;
            toycpu_pkg::S_MULDIV:
                if (sts.md_done)
                    state_next = toycpu_pkg::S_COMMIT;
            toycpu_pkg::S_COMMIT:
                // hold while the previous result beat is still waiting
                if (!sts.out_busy)
                    state_next = toycpu_pkg::S_IDLE;
            default:
                state_next = toycpu_pkg::S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            toycpu_pkg::S_CLEAR:
                cmd.clr_en = 1'b1;
            toycpu_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            toycpu_pkg::S_DECODE:
                cmd.decode = 1'b1;
            toycpu_pkg::S_ISSUE:
            begin
                cmd.issue    = 1'b1;
                cmd.md_start = sts.is_md & ~sts.div_zero;
            end
            toycpu_pkg::S_LOAD:
                cmd.load_cap = 1'b1;
            toycpu_pkg::S_MULDIV:
                cmd.md_cap = sts.md_done;
            toycpu_pkg::S_COMMIT:
                cmd.commit = ~sts.out_busy;
            default:
                cmd = '0;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        sts.md_done |-> (state_reg == toycpu_pkg::S_MULDIV))
        else $error("multiply/divide finished outside its wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == toycpu_pkg::S_LOAD) |=> (state_reg == toycpu_pkg::S_COMMIT))
        else $error("load did not proceed to commit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == toycpu_pkg::S_DECODE))
        else $error("accepted instruction not decoded");

endmodule

// File: rtl/toycpu_cpu_execute_step_core.sv
// Top level of the toy CPU execute step: controller plus datapath.
// Depends on toycpu_pkg, toycpu_if, toycpu_ctrl and toycpu_dpath.
//
//   channel  | dir | payload                                         | handshake
//   ---------+-----+-------------------------------------------------+-------------
//   instr    | in  | instruction[31:0]                               | valid/ready
//   result   | out | status, reg_written, dest_index, write_value,   | valid/ready
//            |     | mem_address, mem_data, carry_flag, pc_value     |
//
// One instruction at a time. After acceptance: decode, issue, then commit;
// register and opcode faults commit straight from decode, add, sub, stores and divide
// by zero straight from issue, loads after a load state (registered memory read),
// mul/div/mod after a wait state (32 steps of the iterative unit plus hand-off).
// The next instruction is accepted the cycle after commit, even while the result
// beat still waits in the output register; commit stalls only if that register is full.
// After reset a clearing pass zeroes all 2^ADDR_BITS data memory addresses
// (65536 at the default) before the first instruction is accepted.
module toy_cpu_execute_step_core #(
    parameter int ADDR_BITS = toycpu_pkg::ADDR_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    toycpu_in_if.sink    instr,
    toycpu_out_if.source result
);
    toycpu_pkg::ctrl_cmd_t  cmd;
    toycpu_pkg::dp_status_t sts;

    toycpu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    toycpu_dpath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .instruction     (instr.instruction),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .out_status      (result.status),
        .out_reg_written (result.reg_written),
        .out_dest_index  (result.dest_index),
        .out_write_value (result.write_value),
        .out_mem_address (result.mem_address),
        .out_mem_data    (result.mem_data),
        .out_carry_flag  (result.carry_flag),
        .out_pc_value    (result.pc_value)
    );

endmodule
